>>> hdl/fwsl_pkg.sv
// Package for the four-wheel slew-limited H-bridge PWM block.
// Shared widths, constants, register indexes and lane control types.
// No dependencies.
package fwsl_pkg;

  localparam int WHEELS    = 4;
  localparam int LVL_W     = 17;
  localparam int RATE_W    = 24;
  localparam int DT_W      = 17;
  localparam int BITS_W    = 5;
  localparam int PROD_W    = RATE_W + DT_W;
  localparam int X_W       = 30;
  localparam int RECIP_W   = 31;
  localparam int RECIP_SH  = 44;

  localparam logic signed [LVL_W-1:0] FULL_POS = 17'sd32768;
  localparam logic signed [LVL_W-1:0] FULL_NEG = -17'sd32768;
  localparam logic [DT_W-1:0]         MAX_DT   = 17'd100000;
  localparam logic [LVL_W-1:0]        STEP_MAX = 17'd65536;
  // rate*dt at or above this gives a step above STEP_MAX
  localparam logic [PROD_W-1:0]       SAT_PROD = 41'd65537000000;
  // ceil(2^44 / 15625); 1e6 = 64 * 15625
  localparam logic [RECIP_W-1:0]      RECIP_M  = 31'd1125899907;
  localparam logic [BITS_W-1:0]       DUTY_MIN = 5'd8;
  localparam logic [BITS_W-1:0]       DUTY_MAX = 5'd16;
  localparam logic [BITS_W-1:0]       DUTY_RST = 5'd10;

  localparam logic [1:0] REG_ACCEL     = 2'd0;
  localparam logic [1:0] REG_DECEL     = 2'd1;
  localparam logic [1:0] REG_DUTY_BITS = 2'd2;

  typedef struct packed {
    logic adv;
    logic take;
    logic stop;
    logic acc_unl;
    logic dec_unl;
  } lane_ctrl_t;

endpackage

>>> hdl/fwsl_step.sv
// Step limit unit: floor(rate * dt / 1e6), capped at 65536.
// Two register stages, reciprocal multiply for the constant divide.
// Depends on fwsl_pkg.
module fwsl_step (
  input  logic                            clk,
  input  logic                            en,
  input  logic [fwsl_pkg::RATE_W-1:0]     rate,
  input  logic [fwsl_pkg::DT_W-1:0]       dt,
  output logic [fwsl_pkg::LVL_W-1:0]      step
);

  logic [fwsl_pkg::PROD_W-1:0]                     prod;
  logic [fwsl_pkg::X_W-1:0]                        x_r;
  logic                                            sat_r;
  logic [fwsl_pkg::X_W+fwsl_pkg::RECIP_W-1:0]      qprod;
  logic [fwsl_pkg::LVL_W-1:0]                      step_r;

  assign prod  = fwsl_pkg::PROD_W'(rate) * fwsl_pkg::PROD_W'(dt);
  assign qprod = (fwsl_pkg::X_W+fwsl_pkg::RECIP_W)'(x_r)
               * (fwsl_pkg::X_W+fwsl_pkg::RECIP_W)'(fwsl_pkg::RECIP_M);

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r  <= (prod >= fwsl_pkg::SAT_PROD);
      x_r    <= prod[fwsl_pkg::X_W+5:6];
      step_r <= sat_r ? fwsl_pkg::STEP_MAX
                      : qprod[fwsl_pkg::RECIP_SH+fwsl_pkg::LVL_W-1:fwsl_pkg::RECIP_SH];
    end
  end

  assign step = step_r;

endmodule

>>> hdl/fwsl_lane.sv
// One wheel lane: held level, asymmetric slew update, duty conversion.
// Level update and duty output are one register stage each.
// Depends on fwsl_pkg.
module fwsl_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fwsl_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [fwsl_pkg::LVL_W-1:0]    target,
  input  logic [fwsl_pkg::LVL_W-1:0]           step_acc,
  input  logic [fwsl_pkg::LVL_W-1:0]           step_dec,
  input  logic [fwsl_pkg::BITS_W-1:0]          duty_bits,
  output logic [fwsl_pkg::LVL_W-1:0]           right_duty,
  output logic [fwsl_pkg::LVL_W-1:0]           left_duty,
  output logic signed [fwsl_pkg::LVL_W-1:0]    level_out
);

  logic signed [fwsl_pkg::LVL_W-1:0] level_r, level_nxt;
  logic [fwsl_pkg::LVL_W-1:0]        right_r, left_r;
  logic signed [fwsl_pkg::LVL_W-1:0] lvl_out_r;

  logic [fwsl_pkg::LVL_W-1:0] abs_t, abs_l, step;
  logic                       toward, unl;
  logic signed [18:0]         diff, step_s;

  logic [15:0]                mag;
  logic [fwsl_pkg::BITS_W-1:0] bits;
  logic [32:0]                scaled;
  logic [fwsl_pkg::LVL_W-1:0] duty;

  always_comb begin
    abs_t  = target[16]  ? 17'(-target)  : 17'(target);
    abs_l  = level_r[16] ? 17'(-level_r) : 17'(level_r);
    toward = abs_t < abs_l;
    unl    = toward ? ctrl.dec_unl : ctrl.acc_unl;
    step   = toward ? step_dec : step_acc;
    step_s = $signed({2'b00, step});
    diff   = 19'(target) - 19'(level_r);
    if (ctrl.stop) begin
      level_nxt = '0;
    end else if (unl) begin
      level_nxt = target;
    end else if (diff > step_s) begin
      level_nxt = 17'(19'(level_r) + step_s);
    end else if (diff < -step_s) begin
      level_nxt = 17'(19'(level_r) - step_s);
    end else begin
      level_nxt = target;
    end
  end

  always_comb begin
    mag    = level_r[16] ? 16'(-level_r) : 16'(level_r);
    if (duty_bits < fwsl_pkg::DUTY_MIN) begin
      bits = fwsl_pkg::DUTY_MIN;
    end else if (duty_bits > fwsl_pkg::DUTY_MAX) begin
      bits = fwsl_pkg::DUTY_MAX;
    end else begin
      bits = duty_bits;
    end
    scaled = (33'(mag) << bits) + 33'd16384;
    duty   = scaled[31:15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (ctrl.take) begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      lvl_out_r <= level_r;
      right_r   <= (!level_r[16] && level_r != '0) ? duty : '0;
      left_r    <= level_r[16] ? duty : '0;
    end
  end

  assign right_duty = right_r;
  assign left_duty  = left_r;
  assign level_out  = lvl_out_r;

endmodule

>>> hdl/four_wheel_slew_limited_hbridge_pwm.sv
// Four-wheel slew-limited H-bridge PWM: top level with pipeline control,
// configuration registers, shared step units and the wheel lanes.
// Depends on fwsl_pkg, fwsl_step, fwsl_lane.
//
// One item per clock sustained, five register stages. The step limits for
// acceleration and deceleration are worked out once per item in two pipelined
// multiply stages shared by all wheels; each wheel lane then updates its held
// level combinationally into its level register, which is what lets items follow
// back to back. The whole pipeline holds while the result waits to be taken. A
// stop item clears all levels and reports zeros.
module four_wheel_slew_limited_hbridge_pwm (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // target_0, target_1, target_2, target_3, step_time_us (17 bits each), pad
  input  logic [87:0]  in_tdata,
  // action
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // right_duty_0, left_duty_0, right_duty_1, left_duty_1, right_duty_2,
  // left_duty_2, right_duty_3, left_duty_3, level_0..level_3 (17 bits), pad
  output logic [207:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  localparam int W = fwsl_pkg::WHEELS;
  localparam int L = fwsl_pkg::LVL_W;

  logic [fwsl_pkg::RATE_W-1:0] accel_r, decel_r;
  logic [fwsl_pkg::BITS_W-1:0] bits_r;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic stop1_r, stop2_r, stop3_r;
  logic signed [L-1:0] tgt1_r [W];
  logic signed [L-1:0] tgt2_r [W];
  logic signed [L-1:0] tgt3_r [W];
  logic [fwsl_pkg::DT_W-1:0] dt1_r, dt_in;
  logic signed [L-1:0] tgt_in [W];

  logic [L-1:0] step_acc, step_dec;
  fwsl_pkg::lane_ctrl_t ctrl;

  logic [L-1:0]        right_d [4];
  logic [L-1:0]        left_d  [4];
  logic signed [L-1:0] lvl_d   [4];

  assign adv       = !v5_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= '0;
      decel_r <= '0;
      bits_r  <= fwsl_pkg::DUTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fwsl_pkg::REG_ACCEL:     accel_r <= cfg_data;
        fwsl_pkg::REG_DECEL:     decel_r <= cfg_data;
        fwsl_pkg::REG_DUTY_BITS: bits_r  <= cfg_data[fwsl_pkg::BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [L-1:0] t;
    for (int w = 0; w < W; w++) begin
      t = $signed(in_tdata[w*L +: L]);
      if (t > fwsl_pkg::FULL_POS) begin
        tgt_in[w] = fwsl_pkg::FULL_POS;
      end else if (t < fwsl_pkg::FULL_NEG) begin
        tgt_in[w] = fwsl_pkg::FULL_NEG;
      end else begin
        tgt_in[w] = t;
      end
    end
    dt_in = in_tdata[4*L +: fwsl_pkg::DT_W];
    if (dt_in > fwsl_pkg::MAX_DT) begin
      dt_in = fwsl_pkg::MAX_DT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stop1_r <= in_tuser;
      stop2_r <= stop1_r;
      stop3_r <= stop2_r;
      dt1_r   <= dt_in;
      for (int w = 0; w < W; w++) begin
        tgt1_r[w] <= tgt_in[w];
        tgt2_r[w] <= tgt1_r[w];
        tgt3_r[w] <= tgt2_r[w];
      end
    end
  end

  fwsl_step u_step_acc (
    .clk  (clk),
    .en   (adv),
    .rate (accel_r),
    .dt   (dt1_r),
    .step (step_acc)
  );

  fwsl_step u_step_dec (
    .clk  (clk),
    .en   (adv),
    .rate (decel_r),
    .dt   (dt1_r),
    .step (step_dec)
  );

  always_comb begin
    ctrl.adv     = adv;
    ctrl.take    = adv && v3_r;
    ctrl.stop    = stop3_r;
    ctrl.acc_unl = (accel_r == '0);
    ctrl.dec_unl = (decel_r == '0);
  end

  for (genvar w = 0; w < 4; w++) begin : g_lane
    if (w < W) begin : g_used
      fwsl_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .target     (tgt3_r[w]),
        .step_acc   (step_acc),
        .step_dec   (step_dec),
        .duty_bits  (bits_r),
        .right_duty (right_d[w]),
        .left_duty  (left_d[w]),
        .level_out  (lvl_d[w])
      );
    end else begin : g_unused
      assign right_d[w] = '0;
      assign left_d[w]  = '0;
      assign lvl_d[w]   = '0;
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int w = 0; w < 4; w++) begin
      out_tdata[(2*w)*L +: L]   = right_d[w];
      out_tdata[(2*w+1)*L +: L] = left_d[w];
      out_tdata[(8+w)*L +: L]   = lvl_d[w];
    end
  end

  assign out_tvalid = v5_r;

endmodule

>>> dv/tb_top.sv
// Testbench for four_wheel_slew_limited_hbridge_pwm: a predictor class tracks the
// four held levels and the registers, and checks every result item field by field.
// Depends on fwsl_pkg and the block's RTL.
`timescale 1ns / 100ps

class wheel_duty_predictor;
  int unsigned accel;
  int unsigned decel;
  bit [4:0] duty_bits;
  int level[fwsl_pkg::WHEELS];
  bit [207:0] expected_duties[$];
  int errors;

  function new();
    accel = 0;
    decel = 0;
    duty_bits = fwsl_pkg::DUTY_RST;
    foreach (level[w]) level[w] = 0;
    errors = 0;
  endfunction

  function void write_reg(bit [1:0] idx, bit [23:0] val);
    case (idx)
      fwsl_pkg::REG_ACCEL: accel = 32'(val);
      fwsl_pkg::REG_DECEL: decel = 32'(val);
      fwsl_pkg::REG_DUTY_BITS: duty_bits = val[4:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_duties.size();
  endfunction

  function int slew_level(int cur, int tgt, int unsigned dt);
    int unsigned rate;
    longint step64;
    int step;
    int diff;
    rate = ((tgt < 0 ? -tgt : tgt) < (cur < 0 ? -cur : cur)) ? decel : accel;
    if (rate == 0) return tgt;
    step64 = (longint'(rate) * longint'(dt)) / 64'sd1000000;
    if (step64 > 64'sd65536) step64 = 64'sd65536;
    step = int'(step64);
    diff = tgt - cur;
    if (diff > step) return cur + step;
    if (diff < -step) return cur - step;
    return tgt;
  endfunction

  function void note_step(bit stop, bit [87:0] data);
    bit [207:0] res;
    int unsigned dt;
    int bits;
    int tgt;
    int mag;
    logic signed [16:0] raw;
    bit [31:0] lv;
    longint duty;
    res = '0;
    dt = 32'(data[84:68]);
    if (dt > 32'(fwsl_pkg::MAX_DT)) dt = 32'(fwsl_pkg::MAX_DT);
    bits = int'(duty_bits);
    if (bits < int'(fwsl_pkg::DUTY_MIN)) bits = int'(fwsl_pkg::DUTY_MIN);
    if (bits > int'(fwsl_pkg::DUTY_MAX)) bits = int'(fwsl_pkg::DUTY_MAX);
    for (int w = 0; w < fwsl_pkg::WHEELS; w++) begin
      if (stop) begin
        level[w] = 0;
      end else begin
        raw = data[17*w +: 17];
        tgt = int'(raw);
        if (tgt > int'(fwsl_pkg::FULL_POS)) tgt = int'(fwsl_pkg::FULL_POS);
        if (tgt < int'(fwsl_pkg::FULL_NEG)) tgt = int'(fwsl_pkg::FULL_NEG);
        level[w] = slew_level(level[w], tgt, dt);
        mag = level[w] < 0 ? -level[w] : level[w];
        duty = ((longint'(mag) << bits) + 64'sd16384) >> 15;
        if (level[w] > 0) res[17*(2*w) +: 17] = duty[16:0];
        else if (level[w] < 0) res[17*(2*w+1) +: 17] = duty[16:0];
        lv = level[w];
        res[17*(8+w) +: 17] = lv[16:0];
      end
    end
    expected_duties.push_back(res);
  endfunction

  function string field_name(int f);
    if (f < 8) return $sformatf("%s_duty_%0d", (f % 2) ? "left" : "right", f / 2);
    return $sformatf("level_%0d", f - 8);
  endfunction

  function void check_duties(bit [207:0] got);
    bit [207:0] want;
    bit [16:0] a;
    bit [16:0] b;
    if (expected_duties.size() == 0) begin
      errors++;
      $display("%0t: unexpected result item 0x%h", $time, got);
      return;
    end
    want = expected_duties.pop_front();
    for (int f = 0; f < 12; f++) begin
      a = want[17*f +: 17];
      b = got[17*f +: 17];
      if (a != b) begin
        errors++;
        $display("%0t: %s expected 0x%05h, got 0x%05h", $time, field_name(f), a, b);
      end
    end
  endfunction
endclass

module tb_top;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 150;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [87:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [207:0] out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [23:0]  cfg_data;

  wheel_duty_predictor pred;
  bit tx_idle;
  bit rx_idle;
  bit [16:0] held[fwsl_pkg::WHEELS];
  int cycles;

  four_wheel_slew_limited_hbridge_pwm dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic bit [16:0] q15(int v);
    bit [31:0] u;
    u = v;
    return u[16:0];
  endfunction

  function automatic bit [16:0] pick_target(bit [16:0] prev);
    int r;
    bit [31:0] u;
    r = $urandom_range(0, 9);
    u = $urandom;
    if (r == 0) begin
      case ($urandom_range(0, 5))
        0: return q15(32768);
        1: return q15(-32768);
        2: return q15(0);
        3: return q15(65535);
        4: return q15(-65536);
        default: return u[16:0];
      endcase
    end
    if (r == 1) return u[16:0];
    if (r <= 5) return prev;
    return q15(int'($urandom_range(0, 65536)) - 32768);
  endfunction

  function automatic bit [16:0] pick_dt();
    bit [31:0] u;
    u = $urandom;
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return u[16:0];
      2: return 17'($urandom_range(100000, 131071));
      3, 4, 5: return 17'($urandom_range(1, 2000));
      default: return 17'($urandom_range(2000, 100000));
    endcase
  endfunction

  function automatic bit [23:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 5000));
      3: return 24'($urandom_range(5000, 500000));
      default: return 24'($urandom_range(500000, 16777215));
    endcase
  endfunction

  function automatic bit [23:0] pick_duty_bits();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 31));
      1: return 24'(fwsl_pkg::DUTY_MIN);
      2: return 24'(fwsl_pkg::DUTY_MAX);
      default: return 24'($urandom_range(8, 16));
    endcase
  endfunction

  task automatic put_reg(bit [1:0] idx, bit [23:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    pred.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    @(negedge clk);
    in_tvalid = 0;
    while (pred.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_step(bit stop, bit [16:0] t0, bit [16:0] t1, bit [16:0] t2,
                           bit [16:0] t3, bit [16:0] dt);
    bit [87:0] d;
    int gap;
    d = {3'b000, dt, t3, t2, t1, t0};
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_tvalid = 0;
      in_tdata = 88'({$urandom, $urandom, $urandom});
      in_tuser = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = d;
    in_tuser = stop;
    do @(posedge clk); while (!in_tready);
    pred.note_step(stop, d);
  endtask

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[four_wheel_slew_limited_hbridge_pwm] ERROR");
    $finish;
  end

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = rx_idle ? $urandom_range(0, 3) : 0;
      out_tready = 0;
      repeat (stall) @(negedge clk);
      out_tready = 1;
      do @(posedge clk); while (!out_tvalid);
      pred.check_duties(out_tdata);
    end
  end

  initial begin
    bit stop;
    pred = new();
    cycles = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    out_tready = 0;
    cfg_we = 0;
    cfg_index = fwsl_pkg::REG_ACCEL;
    cfg_data = '0;
    tx_idle = 1;
    rx_idle = 1;
    foreach (held[w]) held[w] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset registers: unlimited rates, levels jump to targets
    send_step(0, q15(32768), q15(-32768), q15(0), q15(1), 17'd0);
    send_step(0, q15(65535), q15(-65536), q15(32769), q15(-32769), 17'd131071);
    send_step(1, q15(12345), q15(-777), q15(32768), q15(-5), 17'd5000);
    send_step(0, q15(-1), q15(16384), q15(-16384), q15(32767), 17'd100000);

    // slow rates, resolution below range
    settle();
    put_reg(fwsl_pkg::REG_ACCEL, 24'd1000);
    put_reg(fwsl_pkg::REG_DECEL, 24'd500);
    put_reg(fwsl_pkg::REG_DUTY_BITS, 24'd0);
    send_step(0, q15(32768), q15(-32768), q15(100), q15(-100), 17'd100000);
    send_step(0, q15(32768), q15(-32768), q15(100), q15(-100), 17'd131071);
    send_step(0, q15(32768), q15(-32768), q15(100), q15(-100), 17'd999);
    send_step(0, q15(0), q15(0), q15(0), q15(0), 17'd40000);
    send_step(0, q15(-32768), q15(32768), q15(0), q15(0), 17'd100000);

    // max rates saturate the step, resolution above range
    settle();
    put_reg(fwsl_pkg::REG_ACCEL, 24'hFFFFFF);
    put_reg(fwsl_pkg::REG_DECEL, 24'hFFFFFF);
    put_reg(fwsl_pkg::REG_DUTY_BITS, 24'd31);
    send_step(0, q15(32768), q15(-32768), q15(32768), q15(-32768), 17'd100000);
    send_step(0, q15(-32768), q15(32768), q15(1), q15(-1), 17'd100000);
    send_step(0, q15(0), q15(0), q15(0), q15(0), 17'd0);
    send_step(1, q15(32768), q15(32768), q15(32768), q15(32768), 17'd100000);

    // asymmetric: one rate unlimited, the other limited
    settle();
    put_reg(REG_UNUSED, 24'hFFFFFF);
    put_reg(fwsl_pkg::REG_ACCEL, 24'd0);
    put_reg(fwsl_pkg::REG_DECEL, 24'd2000);
    put_reg(fwsl_pkg::REG_DUTY_BITS, 24'd16);
    send_step(0, q15(32768), q15(-32768), q15(20000), q15(-20000), 17'd50000);
    send_step(0, q15(0), q15(0), q15(0), q15(0), 17'd50000);
    settle();
    put_reg(fwsl_pkg::REG_ACCEL, 24'd3000);
    put_reg(fwsl_pkg::REG_DECEL, 24'd0);
    put_reg(fwsl_pkg::REG_DUTY_BITS, 24'd8);
    send_step(0, q15(32768), q15(-32768), q15(-3), q15(3), 17'd100000);
    send_step(0, q15(0), q15(0), q15(0), q15(0), 17'd1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      if ($urandom_range(0, 3) == 0) put_reg(REG_UNUSED, 24'($urandom));
      put_reg(fwsl_pkg::REG_ACCEL, pick_rate());
      put_reg(fwsl_pkg::REG_DECEL, pick_rate());
      put_reg(fwsl_pkg::REG_DUTY_BITS, pick_duty_bits());
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        stop = $urandom_range(0, 24) == 0;
        foreach (held[w]) held[w] = pick_target(held[w]);
        send_step(stop, held[0], held[1], held[2], held[3], pick_dt());
      end
    end

    @(negedge clk);
    in_tvalid = 0;
    while (pred.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pred.errors == 0) begin
      $display("[four_wheel_slew_limited_hbridge_pwm] OK");
    end else begin
      $display("[four_wheel_slew_limited_hbridge_pwm] ERROR");
    end
    $finish;
  end
endmodule
